### src/hsvc_pkg.sv
// Shared types and fixed field widths for the HSV to RGB converter.
// No dependencies; hsv_to_rgb_converter_top imports this package.
`default_nettype none

package hsvc_pkg;

    localparam int HUE_W  = 15;
    localparam int CHAN_W = 13;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        logic [CHAN_W-1:0]       saturation;
        logic [CHAN_W-1:0]       brightness;
    } t_hsv_req;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb_req;

endpackage

`default_nettype wire

### src/hsvc_const_div.sv
// Division of an unsigned value by a constant through a registered reciprocal product.
// Standalone; used twice by hsv_to_rgb_converter_top.
`default_nettype none

module hsvc_const_div #(
    parameter int NUM_W   = 16,
    parameter int DIVISOR = 5760
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    output logic      [NUM_W-1:0] o_quo
);

    // With SHIFT = NUM_W + ceil(log2(DIVISOR)) and a rounded-up reciprocal, the
    // truncated product equals the exact quotient for every NUM_W-bit numerator.
    localparam int          LOG_D  = $clog2(DIVISOR);
    localparam int          SHIFT  = NUM_W + LOG_D;
    localparam int          K_W    = NUM_W + 2;
    localparam int          PROD_W = NUM_W + K_W;
    localparam logic [63:0] RECIP  =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;

    assign n_prod = PROD_W'(i_num) * PROD_W'(RECIP[K_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_quo = NUM_W'(r_prod >> SHIFT);

endmodule

`default_nettype wire

### src/hsv_to_rgb_converter_top.sv
// HSV to RGB colour converter, seven-stage pipeline, top level.
// Depends on hsvc_pkg and hsvc_const_div.
`default_nettype none

//  channel   valid     stall     payload   direction
//  request   i_valid   o_stall   i_hsv     in
//  result    o_valid   i_stall   o_rgb     out
//
// One request is taken every clock while o_stall is low. Its result passes through the
// seven register stages to the outputs; the two reciprocal multipliers (hue wrap and
// sector position) each have a register stage of their own.
// Reset clears only the stage valid bits. A stall from downstream holds the
// last stage; earlier stages keep moving while they have empty slots ahead.

module hsv_to_rgb_converter_top
    import hsvc_pkg::*;
#(
    parameter int FRACTION_BITS        = 12,
    parameter int HUE_STEPS_PER_DEGREE = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_hsv_req i_hsv,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_rgb_req      o_rgb
);

    localparam int NSTG     = 7;
    localparam int W        = 60 * HUE_STEPS_PER_DEGREE;
    localparam int T        = 360 * HUE_STEPS_PER_DEGREE;
    localparam int HUE_SPAN = 1 << (HUE_W - 1);
    localparam int OFS      = T * ((HUE_SPAN + T - 1) / T);
    localparam int UW       = $clog2(OFS + HUE_SPAN);
    localparam int R_W      = $clog2(T);
    localparam int WB       = $clog2(W + 1);
    localparam int NUM_W    = CHAN_W + WB;
    localparam int SV_W     = 2 * CHAN_W + 1;
    localparam int ONE      = 1 << FRACTION_BITS;
    localparam int HALF     = 1 << (FRACTION_BITS - 1);

    localparam logic [2:0] SEC_R_TO_Y = 3'd0;
    localparam logic [2:0] SEC_Y_TO_G = 3'd1;
    localparam logic [2:0] SEC_G_TO_C = 3'd2;
    localparam logic [2:0] SEC_C_TO_B = 3'd3;
    localparam logic [2:0] SEC_B_TO_M = 3'd4;
    localparam logic [2:0] SEC_M_TO_R = 3'd5;

    localparam logic [R_W-1:0] W1 = R_W'(W);
    localparam logic [R_W-1:0] W2 = R_W'(2 * W);
    localparam logic [R_W-1:0] W3 = R_W'(3 * W);
    localparam logic [R_W-1:0] W4 = R_W'(4 * W);
    localparam logic [R_W-1:0] W5 = R_W'(5 * W);

    // Pipeline control: a stage may load when it is empty or the next one loads.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: clamp saturation and brightness, shift the hue to a positive range.
    logic [UW-1:0]     r1_u;
    logic [CHAN_W-1:0] r1_s;
    logic [CHAN_W-1:0] r1_v;
    logic [UW-1:0]     n1_u;
    logic [CHAN_W-1:0] n1_s;
    logic [CHAN_W-1:0] n1_v;

    always_comb begin
        n1_u = UW'(int'(i_hsv.hue) + OFS);
        n1_s = (32'(i_hsv.saturation) > 32'(ONE)) ? CHAN_W'(ONE) : i_hsv.saturation;
        n1_v = (32'(i_hsv.brightness) > 32'(ONE)) ? CHAN_W'(ONE) : i_hsv.brightness;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_u <= n1_u;
            r1_s <= n1_s;
            r1_v <= n1_v;
        end
    end

    // Stage 2: saturation times value, and the hue divided by one full turn.
    logic [UW-1:0]       r2_u;
    logic [2*CHAN_W-1:0] r2_sv;
    logic [CHAN_W-1:0]   r2_v;
    logic [UW-1:0]       w_turns;

    hsvc_const_div #(
        .NUM_W   (UW),
        .DIVISOR (T)
    ) u_turn_div (
        .i_clk (i_clk),
        .i_en  (w_en[1]),
        .i_num (r1_u),
        .o_quo (w_turns)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_u  <= r1_u;
            r2_sv <= (2 * CHAN_W)'(r1_s) * (2 * CHAN_W)'(r1_v);
            r2_v  <= r1_v;
        end
    end

    // Stage 3: wrapped hue and rounded chroma.
    logic [R_W-1:0]    r3_h;
    logic [CHAN_W-1:0] r3_c;
    logic [CHAN_W-1:0] r3_v;
    logic [UW-1:0]     n3_rem;
    logic [SV_W-1:0]   n3_csum;

    always_comb begin
        n3_rem  = r2_u - UW'(w_turns * UW'(T));
        n3_csum = SV_W'(r2_sv) + SV_W'(HALF);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_h <= R_W'(n3_rem);
            r3_c <= CHAN_W'(n3_csum >> FRACTION_BITS);
            r3_v <= r2_v;
        end
    end

    // Stage 4: sector, distance from the sector pair centre, and the offset m.
    logic [2:0]        r4_sec;
    logic [WB-1:0]     r4_wmd;
    logic [CHAN_W-1:0] r4_c;
    logic [CHAN_W-1:0] r4_m;
    logic [2:0]        n4_sec;
    logic [R_W-1:0]    n4_t;
    logic [R_W-1:0]    n4_d;

    always_comb begin
        if (r3_h >= W5) begin
            n4_sec = SEC_M_TO_R;
        end else if (r3_h >= W4) begin
            n4_sec = SEC_B_TO_M;
        end else if (r3_h >= W3) begin
            n4_sec = SEC_C_TO_B;
        end else if (r3_h >= W2) begin
            n4_sec = SEC_G_TO_C;
        end else if (r3_h >= W1) begin
            n4_sec = SEC_Y_TO_G;
        end else begin
            n4_sec = SEC_R_TO_Y;
        end
        if (r3_h >= W4) begin
            n4_t = r3_h - W4;
        end else if (r3_h >= W2) begin
            n4_t = r3_h - W2;
        end else begin
            n4_t = r3_h;
        end
        n4_d = (n4_t >= W1) ? (n4_t - W1) : (W1 - n4_t);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_sec <= n4_sec;
            r4_wmd <= WB'(W1 - n4_d);
            r4_c   <= r3_c;
            r4_m   <= r3_v - r3_c;
        end
    end

    // Stage 5: numerator of the secondary component, rounded half up.
    logic [NUM_W-1:0]  r5_n;
    logic [2:0]        r5_sec;
    logic [CHAN_W-1:0] r5_c;
    logic [CHAN_W-1:0] r5_m;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_n   <= NUM_W'(r4_c) * NUM_W'(r4_wmd) + NUM_W'(W / 2);
            r5_sec <= r4_sec;
            r5_c   <= r4_c;
            r5_m   <= r4_m;
        end
    end

    // Stage 6: divide by the sector width.
    logic [2:0]        r6_sec;
    logic [CHAN_W-1:0] r6_c;
    logic [CHAN_W-1:0] r6_m;
    logic [NUM_W-1:0]  w_x_full;

    hsvc_const_div #(
        .NUM_W   (NUM_W),
        .DIVISOR (W)
    ) u_sector_div (
        .i_clk (i_clk),
        .i_en  (w_en[5]),
        .i_num (r5_n),
        .o_quo (w_x_full)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_sec <= r5_sec;
            r6_c   <= r5_c;
            r6_m   <= r5_m;
        end
    end

    // Stage 7: channel order by sector, then the common offset.
    t_rgb_req          r7_rgb;
    t_rgb_req          n7_rgb;
    logic [CHAN_W-1:0] n7_x;
    logic [CHAN_W-1:0] n7_r;
    logic [CHAN_W-1:0] n7_g;
    logic [CHAN_W-1:0] n7_b;

    always_comb begin
        n7_x = CHAN_W'(w_x_full);
        case (r6_sec)
            SEC_R_TO_Y: begin
                n7_r = r6_c;  n7_g = n7_x;  n7_b = '0;
            end
            SEC_Y_TO_G: begin
                n7_r = n7_x;  n7_g = r6_c;  n7_b = '0;
            end
            SEC_G_TO_C: begin
                n7_r = '0;    n7_g = r6_c;  n7_b = n7_x;
            end
            SEC_C_TO_B: begin
                n7_r = '0;    n7_g = n7_x;  n7_b = r6_c;
            end
            SEC_B_TO_M: begin
                n7_r = n7_x;  n7_g = '0;    n7_b = r6_c;
            end
            default: begin
                n7_r = r6_c;  n7_g = '0;    n7_b = n7_x;
            end
        endcase
        n7_rgb.red   = n7_r + r6_m;
        n7_rgb.green = n7_g + r6_m;
        n7_rgb.blue  = n7_b + r6_m;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_rgb <= n7_rgb;
        end
    end

    assign o_rgb = r7_rgb;

endmodule

`default_nettype wire
